// ===== design/spime_pkg.sv =====
// Package for the SPI master byte engine: item structs and reset constants.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps
package spime_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BIT_W  = 3;
  localparam int unsigned CS_W   = 2;

  // Reset values of the configuration register and the engine state.
  localparam logic [BYTE_W-1:0] DIV_RESET   = 8'd2;
  localparam logic [BIT_W-1:0]  BIT_TOP     = 3'd7;
  localparam logic [BIT_W-1:0]  BIT_LAST    = 3'd0;
  localparam logic              MOSI_RESET  = 1'b1;

  // One input item: a single system clock tick of the pin-level master.
  typedef struct packed {
    logic              write_enable;
    logic [BYTE_W-1:0] tx_byte;
    logic [CS_W-1:0]   card_select;
    logic              miso_card0;
    logic              miso_card1;
  } in_item_t;

  // One result item: the pin and register values after that tick.
  typedef struct packed {
    logic              sclk_out;
    logic              mosi_out;
    logic              busy_flag;
    logic [BYTE_W-1:0] rx_byte;
    logic [CS_W-1:0]   card_select_pins;
  } out_item_t;

  // Handshake status passed from the output register to the engine core.
  typedef struct packed {
    logic space;
  } out_stat_t;

endpackage

// ===== design/spime_ifs.sv =====
// Channel interfaces of the SPI master byte engine: input, result, config.
// Depends on spime_pkg for the field widths.
`timescale 1ns / 1ps
interface spime_in_if import spime_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [BYTE_W-1:0] tx_byte;
  logic [CS_W-1:0]   card_select;
  logic              miso_card0;
  logic              miso_card1;

  modport source (output valid, write_enable, tx_byte, card_select, miso_card0, miso_card1,
                  input ready);
  modport sink   (input valid, write_enable, tx_byte, card_select, miso_card0, miso_card1,
                  output ready);
endinterface

interface spime_out_if import spime_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              sclk_out;
  logic              mosi_out;
  logic              busy_flag;
  logic [BYTE_W-1:0] rx_byte;
  logic [CS_W-1:0]   select_pins;

  modport source (output valid, sclk_out, mosi_out, busy_flag, rx_byte, select_pins,
                  input ready);
  modport sink   (input valid, sclk_out, mosi_out, busy_flag, rx_byte, select_pins,
                  output ready);
endinterface

interface spime_cfg_if import spime_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/spime_in_reg.sv =====
// Input register of the SPI master byte engine: holds one accepted item.
// Depends on spime_pkg and spime_in_if.
`timescale 1ns / 1ps
module spime_in_reg import spime_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  spime_in_if.sink      in_bus,
  input  logic          take,
  output logic          item_valid,
  output in_item_t      item
);

  logic     valid_r, valid_nxt;
  logic     accept;
  in_item_t item_r;

  // A new item enters when the register is empty or is being drained.
  assign in_bus.ready = !valid_r || take;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.write_enable <= in_bus.write_enable;
      item_r.tx_byte      <= in_bus.tx_byte;
      item_r.card_select  <= in_bus.card_select;
      item_r.miso_card0   <= in_bus.miso_card0;
      item_r.miso_card1   <= in_bus.miso_card1;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/spime_core.sv =====
// Engine core of the SPI master: pace counter, bit sequencer, shift registers
// and the clock divider register. Depends on spime_pkg and spime_cfg_if.
`timescale 1ns / 1ps
module spime_core import spime_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  spime_cfg_if.sink     cfg_bus,
  input  logic          item_valid,
  input  in_item_t      item,
  input  out_stat_t     out_stat,
  output logic          fire,
  output out_item_t     result
);

  logic [BYTE_W-1:0] div_r;
  logic [BIT_W-1:0]  bit_pos_r, bit_pos_nxt;
  logic              sclk_r, sclk_nxt;
  logic              mosi_nxt;
  logic              miso_r, miso_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              last_en_r, last_en_nxt;
  logic [BYTE_W-1:0] rx_r, rx_nxt;
  logic              start_edge;
  logic              step;

  // The divider register is always ready; the user must write it only while idle, the block does not enforce it.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= DIV_RESET;
    end else if (cfg_bus.valid) begin
      div_r <= cfg_bus.data;
    end
  end

  // One item is processed whenever an item is held and the result register has room.
  assign fire       = item_valid && out_stat.space;
  assign start_edge = !last_en_r && item.write_enable;
  assign step       = (cnt_r >= div_r) || (start_edge && !busy_r);

  // Next state of the engine for the held item.
  always_comb begin
    bit_pos_nxt = bit_pos_r;
    sclk_nxt    = sclk_r;
    busy_nxt    = busy_r;
    last_en_nxt = last_en_r;
    rx_nxt      = rx_r;
    cnt_nxt     = cnt_r + 8'd1;
    mosi_nxt    = item.tx_byte[bit_pos_r];
    miso_nxt    = item.card_select[0] ? item.miso_card1 : item.miso_card0;
    if (step) begin
      cnt_nxt = '0;
      if (sclk_r) begin
        // Falling step: capture the sampled bit and move down one bit.
        rx_nxt[bit_pos_r] = miso_r;
        sclk_nxt          = 1'b0;
        if (bit_pos_r == BIT_LAST) begin
          bit_pos_nxt = BIT_TOP;
          busy_nxt    = 1'b0;
          last_en_nxt = item.write_enable;
        end else begin
          bit_pos_nxt = bit_pos_r - 3'd1;
        end
      end else if (bit_pos_r == BIT_TOP) begin
        // Idle step: start on a fresh enable edge, otherwise stay idle.
        sclk_nxt    = start_edge;
        busy_nxt    = start_edge;
        last_en_nxt = item.write_enable;
      end else begin
        sclk_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r <= BIT_TOP;
      sclk_r    <= 1'b0;
      miso_r    <= 1'b0;
      cnt_r     <= '0;
      busy_r    <= 1'b0;
      last_en_r <= 1'b0;
      rx_r      <= '0;
    end else if (fire) begin
      bit_pos_r <= bit_pos_nxt;
      sclk_r    <= sclk_nxt;
      miso_r    <= miso_nxt;
      cnt_r     <= cnt_nxt;
      busy_r    <= busy_nxt;
      last_en_r <= last_en_nxt;
      rx_r      <= rx_nxt;
    end
  end

  // The result shows the pins and registers as they stand after this tick.
  assign result.sclk_out         = sclk_nxt;
  assign result.mosi_out         = mosi_nxt;
  assign result.busy_flag        = busy_nxt;
  assign result.rx_byte          = rx_nxt;
  assign result.card_select_pins = item.card_select;

endmodule

// ===== design/spime_out_reg.sv =====
// Result register of the SPI master byte engine; drives the result channel.
// Depends on spime_pkg and spime_out_if.
`timescale 1ns / 1ps
module spime_out_reg import spime_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  out_item_t     result,
  output out_stat_t     stat,
  spime_out_if.source   out_bus
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // Room for a new result when empty or when the held one is taken now.
  assign stat.space = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result;
    end
  end

  assign out_bus.valid       = valid_r;
  assign out_bus.sclk_out    = item_r.sclk_out;
  assign out_bus.mosi_out    = item_r.mosi_out;
  assign out_bus.busy_flag   = item_r.busy_flag;
  assign out_bus.rx_byte     = item_r.rx_byte;
  assign out_bus.select_pins = item_r.card_select_pins;

endmodule

// ===== design/spi_master_byte_engine_top.sv =====
// Top level of the SPI master byte engine (mode 0, MSB first).
// Depends on spime_pkg, spime_ifs, spime_in_reg, spime_core, spime_out_reg.
//
// Usage:
//   Each item on in_bus is one system clock tick of the SPI master: the
//   write enable level, the byte to send, the two active-low card selects
//   and both MISO pins. For every item exactly one item leaves on out_bus
//   with SCLK, MOSI, the busy flag, the received byte and the select pins
//   as they stand after that tick.
//   cfg_bus writes the clock divider (half SCLK period minus one cycle); it
//   is always ready and must be written only while no item is in flight.
//   An accepted item is held in the input register, goes through the engine
//   core and is loaded into the result register, two register stages in all.
//   Throughput: one item per cycle while out_bus does not stall, set by the
//   combinational engine core logic between the input and result registers.
//   Reset clears both stages and puts the engine idle at bit 7 with
//   divider 2. When out_bus stalls, the result register holds its item, the
//   input register takes one more item and then in_bus.ready drops.
`timescale 1ns / 1ps
module spi_master_byte_engine_top import spime_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  spime_in_if.sink      in_bus,
  spime_cfg_if.sink     cfg_bus,
  spime_out_if.source   out_bus
);

  logic      stage_valid;
  in_item_t  stage_item;
  logic      fire;
  out_item_t result;
  out_stat_t out_stat;

  spime_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (fire),
    .item_valid (stage_valid),
    .item       (stage_item)
  );

  spime_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_bus    (cfg_bus),
    .item_valid (stage_valid),
    .item       (stage_item),
    .out_stat   (out_stat),
    .fire       (fire),
    .result     (result)
  );

  spime_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (fire),
    .result  (result),
    .stat    (out_stat),
    .out_bus (out_bus)
  );

  // A result is produced only from an item held in the input register.
  a_fire_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> stage_valid)
    else $error("result produced without a held item");

  // A held item that cannot move on stays in the input register.
  a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid && !out_stat.space |=> stage_valid)
    else $error("held item lost during stall");

  // SCLK is only high while a transfer is in progress.
  a_sclk_busy : assert property (@(posedge clk) disable iff (!rst_n)
    fire && !result.busy_flag |-> !result.sclk_out)
    else $error("SCLK high while idle");

  // An empty input register always takes a new item.
  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !stage_valid |-> in_bus.ready)
    else $error("input refused while stage empty");

endmodule
